// File: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL that carries checks.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define PLM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

// Antecedent implies consequent in the same cycle.
`define PLM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle.
`define PLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/plm_pkg.sv
// Shared types and constants for the peak level meter.
// No dependencies; imported by every module of the block.
package plm_pkg;

  localparam int SampleW = 16;
  localparam int MagW    = 15;
  localparam int LevelW  = 16;
  localparam int CoeffW  = 24;
  localparam int AccW    = 24;
  localparam int WinW    = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;

  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCountW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ATTACK_COEFF  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_COEFF = 2'd2;

  localparam logic [WinW-1:0]   WINDOW_LENGTH_RST = 16'd1024;
  localparam logic [CoeffW-1:0] ATTACK_COEFF_RST  = 24'd1677722;
  localparam logic [CoeffW-1:0] RELEASE_COEFF_RST = 24'd1678;

  // One classified sample handed from front to back
  typedef struct packed {
    logic              wend;    // window closed on this sample
    logic [LevelW-1:0] target;  // log-scaled window peak, valid when wend
  } fitem_t;

  typedef struct packed {
    logic [CoeffW-1:0] attack;
    logic [CoeffW-1:0] release_c;
  } coeffs_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [QCountW-1:0] count;
  } qstat_t;

endpackage

// File: rtl/plm_front.sv
// Front end: accepts samples, tracks the window peak and count,
// and looks up the log ROM at window end. Depends on plm_pkg.
module plm_front import plm_pkg::*; #(
  parameter int LUT_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SampleW-1:0] sample,
  input  logic [WinW-1:0]   window_length,
  output logic              f_valid,
  output fitem_t            f_item,
  input  logic              q_ready
);

  localparam int LutSize = 1 << LUT_BITS;
  localparam int RomW    = LutSize * LevelW;
  localparam logic [31:0] LutMax = 32'(LutSize - 1);

  // Binary log, 30 fraction bits, by repeated squaring
  function automatic logic [63:0] fixed_lg(input logic [31:0] n_in);
    logic [31:0] n;
    logic [4:0]  ip;
    logic [63:0] y;
    logic [63:0] res;
    n  = (n_in == 32'd0) ? 32'd1 : n_in;
    ip = '0;
    for (int k = 0; k < 29; k++) begin
      if ((n >> (k + 1)) != 32'd0) ip = 5'(k + 1);
    end
    y   = {32'd0, n} << (5'd30 - ip);
    res = {59'd0, ip} << 30;
    for (int i = 29; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y      = y >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [63:0] LgD    = fixed_lg(LutMax);
  localparam logic [63:0] LgFull = fixed_lg(32'(40 * (LutSize - 1))) - LgD;

  function automatic logic [RomW-1:0] build_rom();
    logic [RomW-1:0] rom;
    logic [63:0]     l;
    logic [63:0]     v;
    rom = '0;
    for (int a = 0; a < LutSize; a++) begin
      l = fixed_lg(LutMax + 32'(39 * a)) - LgD;
      v = (l * 64'd65536 + (LgFull >> 1)) / LgFull;
      rom[a*LevelW +: LevelW] = (v > 64'd65535) ? 16'hFFFF : v[LevelW-1:0];
    end
    return rom;
  endfunction

  localparam logic [RomW-1:0] LogRom = build_rom();

  logic [MagW-1:0]     window_peak;
  logic [WinW-1:0]     sample_count;
  logic [SampleW:0]    neg;
  logic [MagW-1:0]     mag;
  logic [MagW-1:0]     peak_new;
  logic [WinW-1:0]     wl;
  logic [WinW:0]       cnt_inc;
  logic                wend;
  logic [LUT_BITS-1:0] addr;
  logic                load;

  always_comb begin
    neg = 17'h10000 - {1'b0, sample};
    if (sample[SampleW-1]) begin
      mag = neg[MagW] ? {MagW{1'b1}} : neg[MagW-1:0];
    end else begin
      mag = sample[MagW-1:0];
    end
    peak_new = (mag > window_peak) ? mag : window_peak;
    wl       = (window_length == '0) ? WinW'(1) : window_length;
    cnt_inc  = {1'b0, sample_count} + (WinW+1)'(1);
    wend     = cnt_inc >= {1'b0, wl};
    addr     = peak_new[MagW-1 -: LUT_BITS];
  end

  assign in_ready = !f_valid || q_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_peak  <= '0;
      sample_count <= '0;
      f_valid      <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
      if (wend) begin
        window_peak  <= '0;
        sample_count <= '0;
      end else begin
        window_peak  <= peak_new;
        sample_count <= cnt_inc[WinW-1:0];
      end
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
  end

  // Registered ROM read rides along with the item
  always_ff @(posedge clk) begin
    if (load) begin
      f_item.wend   <= wend;
      f_item.target <= LogRom[{addr, 4'b0000} +: LevelW];
    end
  end

endmodule

// File: rtl/plm_queue.sv
// Short FIFO of classified samples between front and back.
// Depends on plm_pkg for the item type and depth.
module plm_queue import plm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  fitem_t push_item,
  output logic   q_ready,
  input  logic   pop,
  output logic   q_valid,
  output fitem_t q_item,
  output qstat_t q_stat
);

  fitem_t             mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCountW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.count = count;
  assign q_stat.full  = count == QCountW'(QDepth);
  assign q_stat.empty = count == '0;
  assign q_ready      = !q_stat.full;
  assign q_valid      = !q_stat.empty;
  assign q_item       = mem[rd_ptr];
  assign do_push      = push && q_ready;
  assign do_pop       = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCountW'(1);
        2'b01:   count <= count - QCountW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

// File: rtl/plm_back.sv
// Back end: holds the target and runs the attack/release smoother,
// one multiply per item, into the output register. Depends on plm_pkg.
module plm_back import plm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fitem_t            q_item,
  output logic              q_pop,
  input  coeffs_t           coeffs,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LevelW-1:0] level
);

  logic [LevelW-1:0]   held_target;
  logic [AccW-1:0]     smoothed_level;
  logic [AccW-1:0]     smoothed_level_next;
  logic [LevelW-1:0]   tgt;
  logic [AccW-1:0]     target24;
  logic                up;
  logic [CoeffW-1:0]   coeff;
  logic [AccW-1:0]     diff;
  logic [CoeffW+AccW-1:0] prod;
  logic [CoeffW+AccW-1:0] prod_rnd;
  logic [AccW-1:0]     q;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign level = smoothed_level[AccW-1 -: LevelW];

  always_comb begin
    tgt      = q_item.wend ? q_item.target : held_target;
    target24 = {tgt, 8'd0};
    up       = target24 > smoothed_level;
    coeff    = up ? coeffs.attack : coeffs.release_c;
    diff     = up ? (target24 - smoothed_level) : (smoothed_level - target24);
    prod     = coeff * diff;
    // round half up at Q0.24, then apply the sign of the step
    prod_rnd = prod + (CoeffW+AccW)'(1 << 23);
    q        = prod_rnd[CoeffW+AccW-1 -: AccW];
    smoothed_level_next = up ? (smoothed_level + q) : (smoothed_level - q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_target    <= '0;
      smoothed_level <= '0;
      out_valid      <= 1'b0;
    end else if (q_pop) begin
      held_target    <= tgt;
      smoothed_level <= smoothed_level_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/peak_level_meter_ballistics_top.sv
// Peak level meter with log scaling and attack/release smoothing.
// Top level: configuration registers, front, queue and back.
// Depends on plm_pkg, plm_front, plm_queue, plm_back, assert_macros.svh.
//
// Usage:
//   Samples (signed Q1.15) enter on in_valid/in_ready; one smoothed Q0.16
//   level leaves per sample on out_valid/out_ready, in order.
//   Registers are written through cfg_we/cfg_index/cfg_data with no wait:
//   index 0 window length, 1 attack coefficient, 2 release coefficient;
//   other indexes are dropped. Write only while the block is idle.
//   Path: an accepted sample passes the front register, the queue and the
//   output register before its level leaves.
//   Throughput: one sample per cycle unless the output stalls; the smoother's
//   multiply-accumulate feedback on the level register is combinational.
//   A four-entry queue lets the front keep accepting while the output
//   stalls; in_ready drops once the queue and front register are full.
//   Reset clears the window, target, level and all valid flags and loads
//   the default register values; the log ROM is constant, no fill pass.
`include "assert_macros.svh"

module peak_level_meter_ballistics_top import plm_pkg::*; #(
  parameter int LUT_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SampleW-1:0]  sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LevelW-1:0]   level,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [WinW-1:0] window_length;
  coeffs_t         coeffs;
  logic            f_valid;
  fitem_t          f_item;
  logic            q_ready;
  logic            q_valid;
  fitem_t          q_item;
  logic            q_pop;
  qstat_t          q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WINDOW_LENGTH_RST;
      coeffs.attack    <= ATTACK_COEFF_RST;
      coeffs.release_c <= RELEASE_COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: window_length    <= cfg_data[WinW-1:0];
        CFG_ATTACK_COEFF:  coeffs.attack    <= cfg_data[CoeffW-1:0];
        CFG_RELEASE_COEFF: coeffs.release_c <= cfg_data[CoeffW-1:0];
        default:           ;
      endcase
    end
  end

  plm_front #(.LUT_BITS(LUT_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .window_length (window_length),
    .f_valid       (f_valid),
    .f_item        (f_item),
    .q_ready       (q_ready)
  );

  plm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .q_ready   (q_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_stat    (q_stat)
  );

  plm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .coeffs    (coeffs),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level)
  );

  // Input stalls only while the front register holds an item
  `PLM_ASSERT_IMPLY(a_in_stall_front_busy, in_valid && !in_ready, f_valid)
  // Every item popped from the queue shows up on the output next cycle
  `PLM_ASSERT_NEXT(a_pop_gives_output, q_pop, out_valid)
  // Queue flags agree with each other
  `PLM_ASSERT_NEVER(a_queue_flags, q_stat.full && q_stat.empty)

endmodule

// File: verif/plm_meter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the peak level meter: predicts each smoothed level from the
// accepted samples and register writes, then compares the output stream.
// Depends on plm_pkg for widths and register indexes.
module plm_meter_checker import plm_pkg::*; #(
  parameter int LUT_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SampleW-1:0]  sample,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [LevelW-1:0]   level,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  levels_checked
);

  localparam int LutSize = 1 << LUT_BITS;

  logic [LevelW-1:0] log_table [LutSize];
  logic [LevelW-1:0] level_expected_q [$];

  // Predicted registers and datapath state
  logic [WinW-1:0]   win_len;
  logic [CoeffW-1:0] attack_k;
  logic [CoeffW-1:0] release_k;
  logic [MagW-1:0]   peak;
  logic [WinW-1:0]   count;
  logic [LevelW-1:0] target;
  logic [AccW-1:0]   acc;

  // log2 with 30 fraction bits by repeated squaring
  function automatic bit [63:0] lg_q30(input bit [31:0] n);
    bit [31:0] m;
    bit [63:0] y;
    bit [63:0] res;
    int ip;
    m = (n == 0) ? 32'd1 : n;
    ip = 0;
    while (ip < 29 && (m >> (ip + 1)) != 0) ip++;
    y = m;
    y = y << (30 - ip);
    res = ip;
    res = res << 30;
    for (int i = 29; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  initial begin
    bit [31:0] d;
    bit [63:0] lg_d;
    bit [63:0] full;
    bit [63:0] l;
    bit [63:0] v;
    d = LutSize - 1;
    lg_d = lg_q30(d);
    full = lg_q30(40 * d) - lg_d;
    for (int a = 0; a < LutSize; a++) begin
      l = lg_q30(d + 39 * a) - lg_d;
      v = (l * 65536 + full / 2) / full;
      log_table[a] = (v > 65535) ? 16'hFFFF : v[15:0];
    end
  end

  // Advance the meter by one sample and return the level it shows
  function automatic logic [LevelW-1:0] meter_step(input logic [SampleW-1:0] s);
    logic [16:0] mag;
    logic [16:0] wl;
    logic [16:0] nxt;
    logic [AccW-1:0] tgt24;
    logic [AccW-1:0] diff;
    logic up;
    bit [63:0] k;
    bit [63:0] dd;
    bit [63:0] q;
    mag = s[SampleW-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    if (mag > 17'd32767) mag = 17'd32767;
    if (mag[MagW-1:0] > peak) peak = mag[MagW-1:0];
    wl = (win_len == 0) ? 17'd1 : {1'b0, win_len};
    nxt = {1'b0, count} + 17'd1;
    if (nxt >= wl) begin
      target = log_table[peak >> (MagW - LUT_BITS)];
      peak = '0;
      count = '0;
    end else begin
      count = nxt[WinW-1:0];
    end
    tgt24 = {target, 8'h00};
    up = tgt24 > acc;
    k = up ? attack_k : release_k;
    diff = up ? (tgt24 - acc) : (acc - tgt24);
    dd = diff;
    q = (k * dd + (64'd1 << 23)) >> 24;
    acc = up ? (acc + q[AccW-1:0]) : (acc - q[AccW-1:0]);
    return acc[AccW-1:AccW-LevelW];
  endfunction

  always @(posedge clk) begin
    logic [LevelW-1:0] want;
    if (rst) begin
      win_len   = WINDOW_LENGTH_RST;
      attack_k  = ATTACK_COEFF_RST;
      release_k = RELEASE_COEFF_RST;
      peak   = '0;
      count  = '0;
      target = '0;
      acc    = '0;
      level_expected_q.delete();
      errors = 0;
      levels_checked = 0;
    end else begin
      // Retire the output first: it always belongs to an older sample
      if (out_valid && out_ready) begin
        if (level_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] level transaction %0d arrived with nothing expected (got %h)",
                     $time, levels_checked, level);
        end else begin
          want = level_expected_q.pop_front();
          if (level !== want) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] level mismatch at transaction %0d: expected %h got %h",
                       $time, levels_checked, want, level);
          end
        end
        levels_checked++;
      end
      if (in_valid && in_ready)
        level_expected_q.push_back(meter_step(sample));
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: win_len   = cfg_data[WinW-1:0];
          CFG_ATTACK_COEFF:  attack_k  = cfg_data[CoeffW-1:0];
          CFG_RELEASE_COEFF: release_k = cfg_data[CoeffW-1:0];
          default: ;
        endcase
      end
    end
    pending = level_expected_q.size();
  end

endmodule

// File: verif/tb_peak_level_meter_ballistics_top.sv
`timescale 1ns / 1ps
// Testbench top for peak_level_meter_ballistics_top: drives samples, register
// writes and output backpressure; plm_meter_checker predicts and compares.
// Depends on plm_pkg, the block's RTL and verif/plm_meter_checker.sv.
module tb_peak_level_meter_ballistics_top;
  import plm_pkg::*;

  localparam int LUT_BITS    = 10;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SampleW-1:0]  sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LevelW-1:0]   level;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int errors;
  int pending;
  int levels_checked;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_toggle = 1'b0;
  int   samples_sent = 0;
  int   settings_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  peak_level_meter_ballistics_top #(.LUT_BITS(LUT_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  plm_meter_checker #(.LUT_BITS(LUT_BITS)) u_meter_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .level          (level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .levels_checked (levels_checked)
  );

  // Output backpressure; a toggle on hold_toggle starts a long stall
  initial begin
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one sample and hold it until the handshake; leaves in_valid high
  task automatic send_sample(input logic [SampleW-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Rewrite every register, plus a write to the unused index
  task automatic set_config(input logic [CfgDataW-1:0] wl_data,
                            input logic [CfgDataW-1:0] atk,
                            input logic [CfgDataW-1:0] rel);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_data  <= wl_data;
    @(negedge clk);
    cfg_index <= CFG_ATTACK_COEFF;
    cfg_data  <= atk;
    @(negedge clk);
    cfg_index <= CFG_RELEASE_COEFF;
    cfg_data  <= rel;
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input int amp_bits);
    logic signed [SampleW-1:0] raw;
    raw = $urandom;
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return raw >>> (SampleW - amp_bits);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return $urandom_range(4095);
      default: return $urandom_range(24'hFFFFFF);
    endcase
  endfunction

  task automatic random_block(input int n);
    logic [WinW-1:0] wl;
    int amp_bits;
    case ($urandom_range(9))
      0: wl = '0;
      1: wl = 16'hFFFF;
      2, 3, 4, 5: wl = $urandom_range(8, 1);
      6, 7, 8: wl = $urandom_range(64, 9);
      default: wl = $urandom_range(300, 65);
    endcase
    // upper data bits are junk that the register must drop
    set_config({8'($urandom), wl}, pick_coeff(), pick_coeff());
    amp_bits = ($urandom_range(2) == 0) ? $urandom_range(15, 1) : SampleW;
    repeat (n) send_sample(pick_sample(amp_bits));
  endtask

  initial begin
    logic [SampleW-1:0] burst [$];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Window of one (masked write), full-strength attack and release
    set_config(24'hA50001, 24'hFFFFFF, 24'hFFFFFF);
    burst = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
              16'h4000, 16'hBFFF, 16'h0000, 16'h7FFF, 16'h0000};
    foreach (burst[i]) send_sample(burst[i]);

    // Zero window length acts as one; zero weights freeze the level
    set_config(24'h000000, 24'h000000, 24'h000000);
    burst = '{16'h7FFF, 16'h8000, 16'h0000};
    foreach (burst[i]) send_sample(burst[i]);

    // Default weights; then shorten the window to equal the running count
    set_config(24'h000005, ATTACK_COEFF_RST, RELEASE_COEFF_RST);
    burst = '{16'h8000, 16'h0064, 16'hFF38, 16'h2EE0,
              16'hFFFB, 16'h0000, 16'h0007, 16'h6000};
    foreach (burst[i]) send_sample(burst[i]);
    set_config(24'h000003, ATTACK_COEFF_RST, RELEASE_COEFF_RST);
    burst = '{16'h1234, 16'hC000, 16'h0100};
    foreach (burst[i]) send_sample(burst[i]);

    send_idle_pct = 37;
    recv_idle_pct <= 60;
    repeat (3) random_block(50);

    send_idle_pct = 60;
    recv_idle_pct <= 37;
    repeat (3) random_block(50);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_block(50);
    // stall the output while samples keep coming so the input backs up
    hold_toggle <= ~hold_toggle;
    repeat (30) send_sample(pick_sample(SampleW));
    random_block(50);

    drain();
    $display("Covered %0d samples, %0d levels checked, %0d register settings,",
             samples_sent, levels_checked, settings_used);
    $display("three idle mixes and one %0d-cycle output stall", HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
